// File: src/dmwbc_pkg.sv
// Package for the direct-mapped write-back cache controller.
// Holds the word types, the state encoding and the control/status structs.
// Used by dmwbc_ctrl, dmwbc_dpath, the top module and the testbench; depends on nothing.
`default_nettype none

package dmwbc_pkg;

    localparam int LINES_DEFAULT = 16;
    localparam int ADDR_W = 32;
    localparam int DATA_W = 32;
    localparam int LAT_W = 4;

    localparam logic [1:0] FUNC_NONE = 2'd0;
    localparam logic [1:0] FUNC_READ = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_RSVD = 2'd3;
    localparam logic [LAT_W-1:0] MISS_LAT_RESET = 4'd2;

    typedef enum logic [2:0] {
        ST_IDLE       = 3'd0,
        ST_COMPARE    = 3'd1,
        ST_WRITE_BACK = 3'd2,
        ST_READ_MISS  = 3'd3,
        ST_WRITE_MISS = 3'd4,
        ST_HIT        = 3'd5,
        ST_CLEAR      = 3'd6
    } state_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [ADDR_W-1:0] req_addr;
        logic [DATA_W-1:0] req_wdata;
        logic [DATA_W-1:0] mem_read_data;
    } in_t;

    typedef struct packed {
        logic              req_ready;
        logic              mem_busy;
        logic              data_valid;
        logic              was_hit;
        logic [DATA_W-1:0] read_data;
        logic              mem_write_en;
        logic [ADDR_W-1:0] mem_write_addr;
        logic [DATA_W-1:0] mem_write_data;
        logic              mem_read_en;
        logic [ADDR_W-1:0] mem_read_addr;
    } res_t;

    // Commands from the controller to the datapath; all but clear are already qualified by the step.
    typedef struct packed {
        logic clear;
        logic load_req;
        logic hit_upd;
        logic load_victim;
        logic fill;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic victim_dirty;
        logic pend_write;
    } status_t;

    typedef struct packed {
        logic ready;
        logic mem_busy;
        logic data_valid;
        logic was_hit;
        logic wr_en;
        logic rd_en;
    } flags_t;

endpackage

`default_nettype wire

// File: src/dmwbc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are not reset.
`default_nettype none

module dmwbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/dmwbc_ctrl.sv
// Controller of the cache: state machine, wait counter, clearing pass and
// the status flags. Depends on dmwbc_pkg.
`default_nettype none

module dmwbc_ctrl #(
    parameter int LINES = dmwbc_pkg::LINES_DEFAULT,
    localparam int IDX_W = $clog2(LINES)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [1:0]                 func,
    input  logic                       cfg_we,
    input  logic [dmwbc_pkg::LAT_W-1:0] cfg_wdata,
    input  dmwbc_pkg::status_t         status,
    output dmwbc_pkg::cmd_t            cmd,
    output dmwbc_pkg::flags_t          flags,
    output logic                       clearing,
    output logic [IDX_W-1:0]           clr_idx
);

    import dmwbc_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINES - 1);

    state_t           state_reg, state_next;
    logic [LAT_W-1:0] wait_reg, wait_next;
    logic [LAT_W-1:0] lat_reg;
    logic [LAT_W-1:0] wait_inc;
    logic             wait_done;
    flags_t           flags_reg, flags_next;
    logic [IDX_W-1:0] clr_reg, clr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            wait_reg  <= '0;
            lat_reg   <= MISS_LAT_RESET;
            flags_reg <= '{ready: 1'b1, default: 1'b0};
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            flags_reg <= flags_next;
            clr_reg   <= clr_next;
            if (cfg_we)
            begin
                lat_reg <= cfg_wdata;
            end
        end
    end

    assign wait_inc  = wait_reg + LAT_W'(1);
    assign wait_done = (wait_inc >= lat_reg);

    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        flags_next = flags_reg;
        clr_next   = clr_reg;
        cmd        = '0;
        if (state_reg == ST_CLEAR)
        begin
            cmd.clear = 1'b1;
            clr_next  = clr_reg + IDX_W'(1);
            if (clr_reg == LAST_IDX)
            begin
                state_next = ST_IDLE;
            end
        end
        else if (step)
        begin
            flags_next.wr_en = 1'b0;
            flags_next.rd_en = 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (func == FUNC_READ || func == FUNC_WRITE)
                    begin
                        cmd.load_req     = 1'b1;
                        flags_next.ready = 1'b0;
                        state_next       = ST_COMPARE;
                    end
                    else
                    begin
                        flags_next.ready = 1'b1;
                    end
                end
                ST_COMPARE:
                begin
                    flags_next.was_hit = status.hit;
                    if (status.hit)
                    begin
                        cmd.hit_upd           = 1'b1;
                        flags_next.data_valid = 1'b1;
                        state_next            = ST_HIT;
                    end
                    else
                    begin
                        wait_next           = '0;
                        flags_next.mem_busy = 1'b1;
                        if (status.victim_dirty)
                        begin
                            cmd.load_victim = 1'b1;
                            state_next      = ST_WRITE_BACK;
                        end
                        else
                        begin
                            state_next = status.pend_write ? ST_WRITE_MISS : ST_READ_MISS;
                        end
                    end
                end
                ST_WRITE_BACK:
                begin
                    wait_next = wait_inc;
                    if (wait_done)
                    begin
                        flags_next.wr_en    = 1'b1;
                        flags_next.mem_busy = 1'b1;
                        wait_next           = '0;
                        state_next = status.pend_write ? ST_WRITE_MISS : ST_READ_MISS;
                    end
                end
                ST_READ_MISS, ST_WRITE_MISS:
                begin
                    wait_next = wait_inc;
                    if (wait_done)
                    begin
                        cmd.fill              = 1'b1;
                        flags_next.rd_en      = 1'b1;
                        flags_next.data_valid = 1'b1;
                        flags_next.mem_busy   = 1'b0;
                        state_next            = ST_HIT;
                    end
                end
                ST_HIT:
                begin
                    flags_next.ready      = 1'b1;
                    flags_next.data_valid = 1'b0;
                    state_next            = ST_IDLE;
                end
                default:
                begin
                    flags_next.ready = 1'b1;
                    state_next       = ST_IDLE;
                end
            endcase
        end
    end

    assign flags    = flags_reg;
    assign clearing = (state_reg == ST_CLEAR);
    assign clr_idx  = clr_reg;

endmodule

`default_nettype wire

// File: src/dmwbc_dpath.sv
// Datapath of the cache: pending request, victim and result registers and
// the line store. Depends on dmwbc_pkg and dmwbc_ram.
`default_nettype none

module dmwbc_dpath #(
    parameter int LINES = dmwbc_pkg::LINES_DEFAULT,
    localparam int IDX_W = $clog2(LINES)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dmwbc_pkg::in_t               item,
    input  dmwbc_pkg::cmd_t              cmd,
    input  logic [IDX_W-1:0]             clr_idx,
    output dmwbc_pkg::status_t           status,
    output logic [dmwbc_pkg::ADDR_W-1:0] pend_addr,
    output logic [dmwbc_pkg::ADDR_W-1:0] victim_addr,
    output logic [dmwbc_pkg::DATA_W-1:0] victim_data,
    output logic [dmwbc_pkg::DATA_W-1:0] out_word
);

    import dmwbc_pkg::*;

    localparam int TAG_W = ADDR_W - IDX_W;
    localparam int ENT_W = 2 + TAG_W + DATA_W;

    logic [ADDR_W-1:0] pend_addr_reg;
    logic [DATA_W-1:0] pend_data_reg;
    logic              pend_wr_reg;
    logic [ADDR_W-1:0] victim_addr_reg;
    logic [DATA_W-1:0] victim_data_reg;
    logic [DATA_W-1:0] out_word_reg;

    logic [ENT_W-1:0]  rd_ent;
    logic              rd_valid;
    logic              rd_dirty;
    logic [TAG_W-1:0]  rd_tag;
    logic [DATA_W-1:0] rd_word;
    logic [IDX_W-1:0]  pend_idx;
    logic [TAG_W-1:0]  pend_tag;
    logic [DATA_W-1:0] fill_word;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic              req_is_write;

    // A line entry is {valid, dirty, tag, word}.
    assign rd_valid = rd_ent[ENT_W-1];
    assign rd_dirty = rd_ent[ENT_W-2];
    assign rd_tag   = rd_ent[DATA_W +: TAG_W];
    assign rd_word  = rd_ent[DATA_W-1:0];

    assign pend_idx     = pend_addr_reg[IDX_W-1:0];
    assign pend_tag     = pend_addr_reg[ADDR_W-1:IDX_W];
    assign fill_word    = pend_wr_reg ? pend_data_reg : item.mem_read_data;
    assign req_is_write = (item.func == FUNC_WRITE);

    assign status.hit          = rd_valid && (rd_tag == pend_tag);
    assign status.victim_dirty = rd_valid && rd_dirty;
    assign status.pend_write   = pend_wr_reg;

    always_comb
    begin
        ram_we    = cmd.clear || cmd.fill || (cmd.hit_upd && pend_wr_reg);
        ram_waddr = cmd.clear ? clr_idx : pend_idx;
        if (cmd.clear)
        begin
            ram_wdata = '0;
        end
        else if (cmd.fill)
        begin
            ram_wdata = {1'b1, pend_wr_reg, pend_tag, fill_word};
        end
        else
        begin
            ram_wdata = {1'b1, 1'b1, pend_tag, pend_data_reg};
        end
    end

    // The line is read when a request is taken, so its entry is ready for the compare.
    dmwbc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (LINES)
    ) u_lines (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.load_req),
        .raddr (item.req_addr[IDX_W-1:0]),
        .rdata (rd_ent)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_addr_reg   <= '0;
            pend_data_reg   <= '0;
            pend_wr_reg     <= 1'b0;
            victim_addr_reg <= '0;
            victim_data_reg <= '0;
            out_word_reg    <= '0;
        end
        else
        begin
            if (cmd.load_req)
            begin
                pend_addr_reg <= item.req_addr;
                pend_wr_reg   <= req_is_write;
                pend_data_reg <= req_is_write ? item.req_wdata : '0;
            end
            if (cmd.load_victim)
            begin
                victim_addr_reg <= {rd_tag, pend_idx};
                victim_data_reg <= rd_word;
            end
            if (cmd.hit_upd)
            begin
                out_word_reg <= pend_wr_reg ? pend_data_reg : rd_word;
            end
            else if (cmd.fill)
            begin
                out_word_reg <= fill_word;
            end
        end
    end

    assign pend_addr   = pend_addr_reg;
    assign victim_addr = victim_addr_reg;
    assign victim_data = victim_data_reg;
    assign out_word    = out_word_reg;

endmodule

`default_nettype wire

// File: src/direct_mapped_writeback_cache_fsm.sv
// Direct-mapped, one-word-per-line, write-back, write-allocate cache controller.
// Depends on dmwbc_pkg, dmwbc_ctrl, dmwbc_dpath and dmwbc_ram.
//
// Each word on item is one tick of the controller: the CPU request (func,
// req_addr, req_wdata) and the memory word for a fill. A word is taken at a
// rising edge where start is high and busy is low. Exactly one result word
// follows, on result with done high for one cycle, in the cycle after the word
// was taken. A new word may be taken in every cycle, so the sustained rate is
// one word per cycle; the line store is read when a request is taken and its
// registered read data serves the compare tick that follows.
// The result shows the controller flags after that tick, the returned word
// and the memory write and read strobes with their addresses.
// The receiver cannot stall: each result is valid for its one cycle only.
// After reset busy stays high while a clearing pass marks every line invalid;
// miss_latency resets to 2 and may be rewritten on cfg_we / cfg_wdata whenever no
// request is in flight.
// LINES must be a power of two.
`default_nettype none

module direct_mapped_writeback_cache_fsm #(
    parameter int LINES = dmwbc_pkg::LINES_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  dmwbc_pkg::in_t              item,
    output logic                        done,
    output dmwbc_pkg::res_t             result,
    input  logic                        cfg_we,
    input  logic [dmwbc_pkg::LAT_W-1:0] cfg_wdata
);

    import dmwbc_pkg::*;

    localparam int IDX_W = $clog2(LINES);

    logic              step;
    logic              done_reg;
    logic              clearing;
    logic [IDX_W-1:0]  clr_idx;
    cmd_t              cmd;
    status_t           status;
    flags_t            flags;
    logic [ADDR_W-1:0] pend_addr;
    logic [ADDR_W-1:0] victim_addr;
    logic [DATA_W-1:0] victim_data;
    logic [DATA_W-1:0] out_word;

    assign busy = clearing;
    assign step = start && !busy;

    dmwbc_ctrl #(
        .LINES (LINES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .func      (item.func),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .status    (status),
        .cmd       (cmd),
        .flags     (flags),
        .clearing  (clearing),
        .clr_idx   (clr_idx)
    );

    dmwbc_dpath #(
        .LINES (LINES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .cmd         (cmd),
        .clr_idx     (clr_idx),
        .status      (status),
        .pend_addr   (pend_addr),
        .victim_addr (victim_addr),
        .victim_data (victim_data),
        .out_word    (out_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= step;
        end
    end

    assign done = done_reg;

    always_comb
    begin
        result.req_ready      = flags.ready;
        result.mem_busy       = flags.mem_busy;
        result.data_valid     = flags.data_valid;
        result.was_hit        = flags.was_hit;
        result.read_data      = out_word;
        result.mem_write_en   = flags.wr_en;
        result.mem_write_addr = flags.wr_en ? victim_addr : '0;
        result.mem_write_data = flags.wr_en ? victim_data : '0;
        result.mem_read_en    = flags.rd_en;
        result.mem_read_addr  = flags.rd_en ? pend_addr : '0;
    end

    a_done_follows_take: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result word without a taken request word");

    a_no_wr_rd_same_tick: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.mem_write_en && result.mem_read_en))
        else $error("write-back and fill in the same tick");

    a_fill_gives_data: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.mem_read_en |-> result.data_valid && !result.mem_busy)
        else $error("fill completed without returning data");

    a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cmd.load_req && !cmd.fill && !cmd.hit_upd)
        else $error("line store touched by a request during the clearing pass");

endmodule

`default_nettype wire

// File: verif/tb_direct_mapped_writeback_cache_fsm.sv
// Testbench for the direct-mapped write-back cache controller: drives one controller tick
// per word, predicts every result word in a cycle-level model and checks them field by field.
// Depends on dmwbc_pkg and direct_mapped_writeback_cache_fsm.
`default_nettype none

module tb_direct_mapped_writeback_cache_fsm;
    import dmwbc_pkg::*;

    localparam int IDX_W = $clog2(LINES_DEFAULT);
    localparam int TAG_W = ADDR_W - IDX_W;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    in_t item = '0;
    logic done;
    res_t result;
    logic cfg_we = 1'b0;
    logic [LAT_W-1:0] cfg_wdata = '0;

    direct_mapped_writeback_cache_fsm dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Controller model state.
    logic [LAT_W-1:0] miss_lat = MISS_LAT_RESET;
    state_t c_state = ST_IDLE;
    logic [ADDR_W-1:0] p_addr = '0;
    logic [DATA_W-1:0] p_data = '0;
    logic p_wr = 1'b0;
    logic last_hit = 1'b0;
    logic [ADDR_W-1:0] v_addr = '0;
    logic [DATA_W-1:0] v_data = '0;
    logic [LAT_W-1:0] wait_cnt = '0;
    logic rdy_flag = 1'b1;
    logic busy_flag = 1'b0;
    logic vld_flag = 1'b0;
    logic [DATA_W-1:0] out_word = '0;
    logic line_v [LINES_DEFAULT] = '{default: 1'b0};
    logic line_d [LINES_DEFAULT] = '{default: 1'b0};
    logic [TAG_W-1:0] line_tag [LINES_DEFAULT] = '{default: '0};
    logic [DATA_W-1:0] line_word [LINES_DEFAULT] = '{default: '0};

    in_t tick_q[$];
    res_t status_due[$];
    int n_sent = 0;
    int n_taken = 0;
    int errors = 0;
    int cycles = 0;
    int gap_pct = 22;
    logic taken = 1'b0;

    logic [TAG_W-1:0] tag_pool [4] = '{'0, TAG_W'(1), '1, TAG_W'('h5A5A5A5)};

    task automatic cache_tick(input in_t w, output res_t r);
        logic [IDX_W-1:0] idx;
        logic [TAG_W-1:0] tg;
        logic wr_en;
        logic rd_en;
        idx = p_addr[IDX_W-1:0];
        tg = p_addr[ADDR_W-1:IDX_W];
        wr_en = 1'b0;
        rd_en = 1'b0;
        case (c_state)
            ST_IDLE:
            begin
                if (w.func == FUNC_READ || w.func == FUNC_WRITE)
                begin
                    p_addr = w.req_addr;
                    p_wr = (w.func == FUNC_WRITE);
                    p_data = p_wr ? w.req_wdata : '0;
                    c_state = ST_COMPARE;
                    rdy_flag = 1'b0;
                end
                else
                begin
                    rdy_flag = 1'b1;
                end
            end
            ST_COMPARE:
            begin
                if (line_v[idx] && line_tag[idx] == tg)
                begin
                    last_hit = 1'b1;
                    if (p_wr)
                    begin
                        line_word[idx] = p_data;
                        line_d[idx] = 1'b1;
                    end
                    out_word = line_word[idx];
                    vld_flag = 1'b1;
                    c_state = ST_HIT;
                end
                else
                begin
                    last_hit = 1'b0;
                    wait_cnt = '0;
                    busy_flag = 1'b1;
                    if (line_v[idx] && line_d[idx])
                    begin
                        c_state = ST_WRITE_BACK;
                        v_addr = {line_tag[idx], idx};
                        v_data = line_word[idx];
                    end
                    else
                    begin
                        c_state = p_wr ? ST_WRITE_MISS : ST_READ_MISS;
                    end
                end
            end
            ST_WRITE_BACK:
            begin
                wait_cnt = wait_cnt + LAT_W'(1);
                if (wait_cnt >= miss_lat)
                begin
                    wr_en = 1'b1;
                    line_d[idx] = 1'b0;
                    c_state = p_wr ? ST_WRITE_MISS : ST_READ_MISS;
                    wait_cnt = '0;
                    busy_flag = 1'b1;
                end
            end
            ST_READ_MISS, ST_WRITE_MISS:
            begin
                wait_cnt = wait_cnt + LAT_W'(1);
                if (wait_cnt >= miss_lat)
                begin
                    rd_en = 1'b1;
                    line_tag[idx] = tg;
                    line_v[idx] = 1'b1;
                    line_d[idx] = p_wr;
                    line_word[idx] = p_wr ? p_data : w.mem_read_data;
                    out_word = line_word[idx];
                    vld_flag = 1'b1;
                    busy_flag = 1'b0;
                    c_state = ST_HIT;
                end
            end
            ST_HIT:
            begin
                rdy_flag = 1'b1;
                vld_flag = 1'b0;
                c_state = ST_IDLE;
            end
            default:
            begin
                rdy_flag = 1'b1;
                c_state = ST_IDLE;
            end
        endcase
        r.req_ready = rdy_flag;
        r.mem_busy = busy_flag;
        r.data_valid = vld_flag;
        r.was_hit = last_hit;
        r.read_data = out_word;
        r.mem_write_en = wr_en;
        r.mem_write_addr = wr_en ? v_addr : '0;
        r.mem_write_data = wr_en ? v_data : '0;
        r.mem_read_en = rd_en;
        r.mem_read_addr = rd_en ? p_addr : '0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Results are checked before the word taken at this edge is predicted, since the
    // result of a word appears in the cycle after it is taken.
    always @(posedge clk)
    begin
        res_t want;
        res_t next_res;
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_direct_mapped_writeback_cache_fsm NOT OK");
            $finish;
        end
        if (!rst_n)
        begin
            taken = 1'b0;
        end
        else
        begin
            if (done !== 1'b0)
            begin
                if (status_due.size() == 0)
                begin
                    $display("%0t: unexpected result word %h", $time, result);
                    errors++;
                end
                else
                begin
                    want = status_due.pop_front();
                    check_field("req_ready", 32'(want.req_ready), 32'(result.req_ready));
                    check_field("mem_busy", 32'(want.mem_busy), 32'(result.mem_busy));
                    check_field("data_valid", 32'(want.data_valid), 32'(result.data_valid));
                    check_field("was_hit", 32'(want.was_hit), 32'(result.was_hit));
                    check_field("read_data", want.read_data, result.read_data);
                    check_field("mem_write_en", 32'(want.mem_write_en),
                                32'(result.mem_write_en));
                    check_field("mem_write_addr", want.mem_write_addr, result.mem_write_addr);
                    check_field("mem_write_data", want.mem_write_data, result.mem_write_data);
                    check_field("mem_read_en", 32'(want.mem_read_en),
                                32'(result.mem_read_en));
                    check_field("mem_read_addr", want.mem_read_addr, result.mem_read_addr);
                end
            end
            taken = start && !busy;
            if (taken)
            begin
                cache_tick(item, next_res);
                status_due.push_back(next_res);
                n_taken++;
            end
            if (cfg_we)
                miss_lat = cfg_wdata;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!start || taken))
        begin
            if (tick_q.size() > 0 && $urandom_range(0, 99) >= gap_pct)
            begin
                item <= tick_q.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    task automatic push_tick(input logic [1:0] f, input logic [31:0] a, input logic [31:0] d,
                             input logic [31:0] m);
        in_t w;
        w.func = f;
        w.req_addr = a;
        w.req_wdata = d;
        w.mem_read_data = m;
        tick_q.push_back(w);
        n_sent++;
    endtask

    task automatic push_quiet(input int n);
        repeat (n) push_tick(FUNC_NONE, $urandom, $urandom, $urandom);
    endtask

    function automatic logic [31:0] pick_data();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Most addresses share a few tags so that lines are hit, refilled and evicted dirty.
    task automatic push_random(input int n);
        logic [1:0] f;
        logic [31:0] a;
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: f = FUNC_READ;
                4, 5, 6, 7: f = FUNC_WRITE;
                8: f = FUNC_NONE;
                default: f = FUNC_RSVD;
            endcase
            case ($urandom_range(0, 9))
                7: a = $urandom;
                8: a = '0;
                9: a = '1;
                default: a = {tag_pool[$urandom_range(0, 3)], IDX_W'($urandom)};
            endcase
            push_tick(f, a, pick_data(), pick_data());
        end
    endtask

    // Waits until every word has been taken and answered, and the controller has
    // returned to idle, so that the latency can be changed safely.
    task automatic settle();
        do
        begin
            while (n_taken != n_sent || status_due.size() != 0)
                @(negedge clk);
            if (c_state != ST_IDLE)
                push_quiet(1);
        end
        while (n_taken != n_sent || status_due.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic run_phase(input logic [LAT_W-1:0] lat, input int pct, input int n);
        settle();
        cfg_wdata = lat;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        gap_pct = pct;
        push_random(n);
    endtask

    initial
    begin
        // Directed words run at the reset latency.
        push_tick(FUNC_WRITE, 32'h0, 32'hFFFF_FFFF, 32'h0);
        push_quiet(4);
        push_tick(FUNC_READ, 32'h0, 32'h1234_5678, 32'h0);
        push_quiet(2);
        push_tick(FUNC_READ, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        push_quiet(4);
        // Same line, other tag: the dirty word goes back before the write miss.
        // Requests offered meanwhile must be ignored.
        push_tick(FUNC_WRITE, 32'h10, 32'h0, 32'hA5A5_A5A5);
        repeat (3)
        begin
            push_tick(FUNC_READ, $urandom, $urandom, $urandom);
            push_tick(FUNC_WRITE, $urandom, $urandom, $urandom);
        end
        push_tick(FUNC_RSVD, 32'h20, 32'h5555_5555, 32'h0);
        push_tick(FUNC_READ, 32'h10, 32'h0, 32'h0);
        push_quiet(2);
        push_tick(FUNC_READ, 32'hFFFF_FFF0, 32'h0, 32'h8000_0001);
        push_quiet(6);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_phase(4'd1, 22, 400);
        run_phase(4'd15, 22, 300);
        run_phase(4'd0, 83, 300);
        run_phase(4'd8, 83, 300);
        run_phase(4'd3, 0, 300);
        run_phase(4'd2, 0, 300);
        settle();

        if (errors == 0)
            $display("tb_direct_mapped_writeback_cache_fsm OK");
        else
            $display("tb_direct_mapped_writeback_cache_fsm NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
src/dmwbc_pkg.sv
src/dmwbc_ram.sv
src/dmwbc_ctrl.sv
src/dmwbc_dpath.sv
src/direct_mapped_writeback_cache_fsm.sv
verif/tb_direct_mapped_writeback_cache_fsm.sv
